// ----- rtl/decimal_entry_parser_core_defines.svh -----
// assertion macros shared by the parser core
`ifndef DECIMAL_ENTRY_PARSER_CORE_DEFINES_SVH
`define DECIMAL_ENTRY_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser core check failed");

// next-cycle implication, checked outside reset
`define DEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser core check failed");

`endif

// ----- rtl/dep_pkg.sv -----
package dep_pkg;

  localparam logic [7:0]  CODE_ERASE = 8'd127;
  localparam logic [7:0]  CODE_CR    = 8'd13;
  localparam logic [7:0]  CODE_ZERO  = 8'd48;
  localparam logic [3:0]  DIGIT_MAX  = 4'd9;
  localparam logic [19:0] RADIX      = 20'd10;
  localparam logic [28:0] RECIP_TEN  = 29'd6554;
  localparam logic [7:0]  COUNT_MAX  = 8'hFF;
  localparam logic [15:0] MAX_RESET  = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_ERASE,
    OP_ENTER
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
  } cmd_t;

endpackage

// ----- rtl/dep_front.sv -----
module dep_front (
  input  logic          in_valid,
  input  logic [7:0]    in_char,
  input  logic          q_full,
  output logic          in_stall,
  output logic          push,
  output dep_pkg::cmd_t cmd
);
  import dep_pkg::*;

  logic [7:0] offset;
  logic       is_digit;

  assign offset   = in_char - CODE_ZERO;
  assign is_digit = (offset[7:4] == 4'd0) && (offset[3:0] <= DIGIT_MAX);

  // queue full holds the link; other bytes are taken and dropped here
  assign in_stall = q_full;

  always_comb begin
    cmd.digit = offset[3:0];
    cmd.op    = OP_DIGIT;
    push      = 1'b0;
    if (in_char == CODE_ERASE) begin
      cmd.op = OP_ERASE;
      push   = in_valid && !q_full;
    end else if (in_char == CODE_CR) begin
      cmd.op = OP_ENTER;
      push   = in_valid && !q_full;
    end else if (is_digit) begin
      push = in_valid && !q_full;
    end
  end

endmodule

// ----- rtl/dep_queue.sv -----
module dep_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dep_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          head_valid,
  output dep_pkg::cmd_t head_cmd,
  output logic          full
);
  import dep_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/dep_back.sv -----
module dep_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   max_value,
  input  logic          head_valid,
  input  dep_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          kind,
  output logic [7:0]    echo_char,
  output logic [15:0]   value,
  output logic          last
);
  import dep_pkg::*;

  logic [15:0] acc_value;
  logic [7:0]  key_count;
  logic        phase;

  logic        load_ok;
  logic [19:0] digit_next;
  logic [28:0] erase_prod;
  logic        over;
  logic        lone_zero;
  logic        ignore;
  logic        emit;
  logic        emit_kind;
  logic [7:0]  emit_char;
  logic [15:0] emit_value;
  logic        emit_last;
  logic        phase_next;

  assign load_ok    = !out_valid || !out_stall;
  assign digit_next = {4'd0, acc_value} * RADIX + {16'd0, head_cmd.digit};
  assign erase_prod = {13'd0, acc_value} * RECIP_TEN;
  assign over       = digit_next > {4'd0, max_value};
  assign lone_zero  = (acc_value == 16'd0) && (key_count != 8'd0);
  assign ignore     = over || (lone_zero && (head_cmd.digit == 4'd0));

  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    emit_kind  = 1'b0;
    emit_char  = 8'd0;
    emit_value = 16'd0;
    emit_last  = 1'b1;
    phase_next = phase;
    if (head_valid) begin
      case (head_cmd.op)
        OP_ENTER: begin
          emit       = 1'b1;
          emit_kind  = 1'b1;
          emit_value = acc_value;
          pop        = load_ok;
        end
        OP_ERASE: begin
          emit      = 1'b1;
          emit_char = CODE_ERASE;
          pop       = load_ok;
        end
        OP_DIGIT: begin
          if (ignore) begin
            pop = 1'b1;
          end else if (lone_zero && !phase) begin
            // wipe the lone zero on the terminal before echoing the digit
            emit      = 1'b1;
            emit_char = CODE_ERASE;
            emit_last = 1'b0;
            if (load_ok) begin
              phase_next = 1'b1;
            end
          end else begin
            emit      = 1'b1;
            emit_char = CODE_ZERO + {4'd0, head_cmd.digit};
            pop       = load_ok;
            if (load_ok) begin
              phase_next = 1'b0;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_value <= 16'd0;
      key_count <= 8'd0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load_ok) begin
        out_valid <= emit;
      end
      if (pop) begin
        case (head_cmd.op)
          OP_ENTER: begin
            acc_value <= 16'd0;
            key_count <= 8'd0;
          end
          OP_ERASE: begin
            acc_value <= erase_prod[28:16] == 13'd0 ? 16'd0 : {3'd0, erase_prod[28:16]};
            if (key_count != 8'd0) begin
              key_count <= key_count - 8'd1;
            end
          end
          OP_DIGIT: begin
            if (!ignore) begin
              acc_value <= digit_next[15:0];
              if (key_count != COUNT_MAX) begin
                key_count <= key_count + 8'd1;
              end
            end
          end
          default: begin
            acc_value <= acc_value;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && emit) begin
      kind      <= emit_kind;
      echo_char <= emit_char;
      value     <= emit_value;
      last      <= emit_last;
    end
  end

endmodule

// ----- rtl/decimal_entry_parser_core.sv -----
// Decimal entry parser: typed bytes come in on the in channel one word per cycle
// while in_stall is low, and echo words and finished numbers leave on the out
// channel. A front stage sorts each byte into digit, erase or carriage return
// (other bytes are taken and dropped) and queues it; a back stage owns the value
// and keystroke count and emits one result per cycle into an output register
// while the output is not stalled. An erase or return gives one result, a digit
// that replaces a lone zero gives two (erase echo, then digit echo), and a digit
// that is refused is dropped with no result. With the queue empty, the first
// result of a byte passes through the queue and then the output register. The
// queue depth sets how long the input keeps flowing while the output is stalled.
// max_value is written on the cfg channel, which is always ready, and should
// only change while no byte is in flight.
module decimal_entry_parser_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_value,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  echo_char,
  output logic [15:0] value,
  output logic        last
);
  import dep_pkg::*;

  `include "decimal_entry_parser_core_defines.svh"

  logic [15:0] max_reg;
  logic        q_push;
  logic        q_full;
  cmd_t        push_cmd;
  cmd_t        head_cmd;
  logic        head_valid;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_reg <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_reg <= max_value;
    end
  end

  dep_front u_front (
    .in_valid (in_valid),
    .in_char  (in_char),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  dep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (q_full)
  );

  dep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .max_value  (max_reg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .echo_char  (echo_char),
    .value      (value),
    .last       (last)
  );

  // a full queue never takes a word
  `DEP_ASSERT_IMP(a_no_push_when_full, q_full, !q_push)
  // a number word is always the last word of its byte and carries no echo
  `DEP_ASSERT_IMP(a_number_is_last, out_valid && kind, last && (echo_char == 8'd0))
  // only the lone-zero erase echo is followed by a further word
  `DEP_ASSERT_IMP(a_early_word_is_erase, out_valid && !last,
                  !kind && (echo_char == CODE_ERASE))
  // after an early word is taken, the digit echo follows right away
  `DEP_ASSERT_NXT(a_digit_follows_erase, out_valid && !last && !out_stall,
                  out_valid && last && !kind)

endmodule

// ----- tb/sv/tb_decimal_entry_parser_core.sv -----
`timescale 1ns / 1ps

module tb_decimal_entry_parser_core;
  import dep_pkg::*;

  localparam logic KIND_ECHO   = 1'b0;
  localparam logic KIND_NUMBER = 1'b1;
  localparam int IDLE_PCT      = 36;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 83;

  typedef struct packed {
    logic        kind;
    logic [7:0]  echo_char;
    logic [15:0] value;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] max_value = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  echo_char;
  logic [15:0] value;
  logic        last;

  // model of the parser state
  logic [15:0] entry_value;
  logic [7:0]  entry_count;
  logic [15:0] cur_max;

  logic [7:0]  char_queue[$];
  result_t     result_q[$];
  result_t     want;
  logic        in_fired = 1'b0;
  logic        calm;
  int          errors = 0;
  int          items_taken = 0;
  int          results_seen = 0;
  int          cfg_writes = 0;
  int          phase_items;

  decimal_entry_parser_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .max_value (max_value),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .echo_char (echo_char),
    .value     (value),
    .last      (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic result_t make_result(logic k, logic [7:0] ch, logic [15:0] v, logic l);
    result_t r;
    r.kind      = k;
    r.echo_char = ch;
    r.value     = v;
    r.last      = l;
    return r;
  endfunction

  function automatic void predict_keystroke(logic [7:0] c);
    logic [7:0]  dg;
    logic [19:0] nxt;
    logic [31:0] prod;
    dg = c - CODE_ZERO;
    if (c == CODE_ERASE) begin
      result_q.push_back(make_result(KIND_ECHO, CODE_ERASE, 16'd0, 1'b1));
      // divide by ten through the fixed-point reciprocal
      prod = 32'(entry_value) * 32'(RECIP_TEN);
      if (entry_value != 16'd0) entry_value = prod[31:16];
      if (entry_count != 8'd0) entry_count = entry_count - 8'd1;
    end else if (c == CODE_CR) begin
      result_q.push_back(make_result(KIND_NUMBER, 8'd0, entry_value, 1'b1));
      entry_value = 16'd0;
      entry_count = 8'd0;
    end else if (dg <= 8'(DIGIT_MAX)) begin
      nxt = 20'(entry_value) * RADIX + 20'(dg);
      if (nxt <= 20'(cur_max) &&
          !(entry_value == 16'd0 && dg == 8'd0 && entry_count != 8'd0)) begin
        // a lone zero on the terminal is rubbed out first
        if (entry_value == 16'd0 && entry_count != 8'd0)
          result_q.push_back(make_result(KIND_ECHO, CODE_ERASE, 16'd0, 1'b0));
        result_q.push_back(make_result(KIND_ECHO, c, 16'd0, 1'b1));
        entry_value = nxt[15:0];
        if (entry_count != COUNT_MAX) entry_count = entry_count + 8'd1;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  assign calm = (items_taken >= 450 && items_taken < 650);

  // driver: changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fired) begin
      // hold the stalled word
    end else if (char_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
      in_valid <= 1'b1;
      in_char  <= char_queue[0];
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // monitor and predictor: sample on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      entry_value = 16'd0;
      entry_count = 8'd0;
      cur_max     = MAX_RESET;
      in_fired    = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cur_max = max_value;
        cfg_writes++;
      end
      in_fired = in_valid && !in_stall;
      if (in_fired) begin
        predict_keystroke(in_char);
        void'(char_queue.pop_front());
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected word: kind=%0d echo=%0d value=%0d last=%0d",
                   $time, kind, echo_char, value, last);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(kind));
          check_field("echo_char", 16'(want.echo_char), 16'(echo_char));
          check_field("value", want.value, value);
          check_field("last", 16'(want.last), 16'(last));
          results_seen++;
        end
      end
    end
  end

  task automatic send(logic [7:0] c);
    char_queue.push_back(c);
    phase_items++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send(s[i]);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (char_queue.size() != 0 || result_q.size() != 0 || (in_valid && !in_fired)) begin
      @(posedge clk);
      #1;
    end
    // refused digits and dropped bytes leave no word behind, so give them time
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    max_value <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed entries, some noise and some left unterminated
  task automatic gen_entry();
    int len;
    int r;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 4)) send(8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(0, 7);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 70)      send(CODE_ZERO + 8'($urandom_range(0, 9)));
        else if (r < 80) send(CODE_ZERO);
        else if (r < 92) send(CODE_ERASE);
        else             send(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 90) send(CODE_CR);
    end
  endtask

  task automatic random_phase();
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) gen_entry();
    wait_idle();
  endtask

  initial begin
    logic [15:0] limits[11];
    limits = '{16'd0, 16'd1, 16'd9, 16'd10, 16'hFFFF, 16'd100, 16'd59999,
               16'd12345, 16'd0, 16'd0, 16'hFFFE};
    limits[8] = 16'($urandom_range(0, 65535));
    limits[9] = 16'($urandom_range(0, 999));
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // leading zeros, largest value, refused digit, erase on empty, odd bytes
    send_str("005\015");
    send_str("65535\015");
    send_str("65536\177\177\015");
    send(CODE_ERASE);
    send(8'h00);
    send(8'hFF);
    send_str("/:\015");
    wait_idle();
    random_phase();

    foreach (limits[i]) begin
      write_max(limits[i]);
      random_phase();
    end

    wait_idle();
    $display("covered %0d keystrokes, %0d result words, %0d max_value writes",
             items_taken, results_seen, cfg_writes);
    if (errors == 0 && result_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
